// ----- design/mcc_pkg.sv -----
// Shared types, widths and register codes for the minimap circle clamp.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

  localparam int W_WORLD = 24;
  localparam int W_DIFF  = 25;
  localparam int W_MAG   = 25;
  localparam int W_SCALE = 12;
  localparam int W_CTR   = 16;
  localparam int W_RAD   = 13;
  localparam int W_SQ    = 50;
  localparam int W_RR    = 26;
  localparam int W_NUM   = 40;
  localparam int W_DEN   = 26;
  localparam int W_Q     = 13;
  localparam int W_CIDX  = 8;
  localparam int W_CDAT  = 16;

  localparam int SQRT_STEPS = W_SQ / 2;
  localparam int DIV_STEPS  = W_Q;

  localparam logic [W_SCALE-1:0] SCALE_RESET  = 12'd256;
  localparam logic [W_RAD-1:0]   RADIUS_RESET = 13'd1280;

  typedef enum logic [W_CIDX-1:0] {
    REG_MAP_SCALE  = 8'd0,
    REG_CENTER_X   = 8'd1,
    REG_CENTER_Y   = 8'd2,
    REG_MAP_RADIUS = 8'd3
  } mcc_reg_t;

  typedef struct packed {
    logic signed [W_WORLD-1:0] object_x;
    logic signed [W_WORLD-1:0] object_z;
    logic signed [W_WORLD-1:0] viewer_x;
    logic signed [W_WORLD-1:0] viewer_z;
    logic                      object_kind;
  } mcc_in_t;

  typedef struct packed {
    logic signed [W_CTR-1:0] icon_x;
    logic signed [W_CTR-1:0] icon_y;
    logic                    icon_kind;
  } mcc_out_t;

  // Per-item side data carried along the cell chains.
  typedef struct packed {
    logic [W_MAG-1:0] ax;
    logic [W_MAG-1:0] ay;
    logic             sx;
    logic             sy;
    logic             kind;
    logic             clamp;
  } mcc_side_t;

endpackage
`default_nettype wire

// ----- design/mcc_sqrt_cell.sv -----
// One digit cell of the integer square root chain.
`timescale 1ns / 1ps
`default_nettype none
module mcc_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [mcc_pkg::W_SQ-1:0] rem_in,
  input  wire logic [mcc_pkg::W_SQ-1:0] root_in,
  input  wire mcc_pkg::mcc_side_t      side_in,
  output logic [mcc_pkg::W_SQ-1:0]     rem,
  output logic [mcc_pkg::W_SQ-1:0]     root,
  output mcc_pkg::mcc_side_t           side
);
  import mcc_pkg::*;

  localparam logic [W_SQ-1:0] BIT = W_SQ'(1) << SHIFT;

  logic [W_SQ-1:0] trial;
  logic [W_SQ-1:0] rem_next;
  logic [W_SQ-1:0] root_next;

  always_comb begin
    trial = root_in + BIT;
    if (rem_in >= trial) begin
      rem_next  = rem_in - trial;
      root_next = (root_in >> 1) + BIT;
    end else begin
      rem_next  = rem_in;
      root_next = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      side <= side_in;
    end
  end

endmodule
`default_nettype wire

// ----- design/mcc_div_cell.sv -----
// One quotient-bit cell of the restoring divider chain, both axes.
`timescale 1ns / 1ps
`default_nettype none
module mcc_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [mcc_pkg::W_NUM-1:0] num_x_in,
  input  wire logic [mcc_pkg::W_NUM-1:0] num_y_in,
  input  wire logic [mcc_pkg::W_DEN-1:0] den_in,
  input  wire logic [mcc_pkg::W_Q-1:0]   q_x_in,
  input  wire logic [mcc_pkg::W_Q-1:0]   q_y_in,
  input  wire mcc_pkg::mcc_side_t        side_in,
  output logic [mcc_pkg::W_NUM-1:0]      num_x,
  output logic [mcc_pkg::W_NUM-1:0]      num_y,
  output logic [mcc_pkg::W_DEN-1:0]      den,
  output logic [mcc_pkg::W_Q-1:0]        q_x,
  output logic [mcc_pkg::W_Q-1:0]        q_y,
  output mcc_pkg::mcc_side_t             side
);
  import mcc_pkg::*;

  localparam logic [W_Q-1:0] QBIT = W_Q'(1) << SHIFT;

  logic [W_NUM-1:0] sub;
  logic [W_NUM-1:0] num_x_next;
  logic [W_NUM-1:0] num_y_next;
  logic [W_Q-1:0]   q_x_next;
  logic [W_Q-1:0]   q_y_next;

  always_comb begin
    sub        = W_NUM'(den_in) << SHIFT;
    num_x_next = num_x_in;
    num_y_next = num_y_in;
    q_x_next   = q_x_in;
    q_y_next   = q_y_in;
    if (num_x_in >= sub) begin
      num_x_next = num_x_in - sub;
      q_x_next   = q_x_in | QBIT;
    end
    if (num_y_in >= sub) begin
      num_y_next = num_y_in - sub;
      q_y_next   = q_y_in | QBIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= num_x_next;
      num_y <= num_y_next;
      den   <= den_in;
      q_x   <= q_x_next;
      q_y   <= q_y_next;
      side  <= side_in;
    end
  end

endmodule
`default_nettype wire

// ----- design/minimap_project_clamp_circle_top.sv -----
// Minimap icon projection with clamp to circle: front stages, cell chains, output.
// Throughput: one item per cycle while out_stall is low; a 25-cell square root
// chain and a 13-cell divider chain each move one item a cycle, and empty
// stages fill behind a stall.
// Reset (rst, synchronous): clears all stage valid bits and loads the register
// defaults (scale 256/4096 = 1/16, center 0, radius 1280). Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none
module minimap_project_clamp_circle_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire mcc_pkg::mcc_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output mcc_pkg::mcc_out_t               out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mcc_pkg::W_CIDX-1:0] cfg_index,
  input  wire logic [mcc_pkg::W_CDAT-1:0] cfg_data
);
  import mcc_pkg::*;

  localparam int SQ0   = 4;
  localparam int MST   = SQ0 + SQRT_STEPS;
  localparam int DV0   = MST + 1;
  localparam int OST   = DV0 + DIV_STEPS;
  localparam int NST   = OST + 1;

  // configuration
  logic [W_SCALE-1:0]      map_scale;
  logic signed [W_CTR-1:0] center_x;
  logic signed [W_CTR-1:0] center_y;
  logic [W_RAD-1:0]        map_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_scale  <= SCALE_RESET;
      center_x   <= '0;
      center_y   <= '0;
      map_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_SCALE:  map_scale  <= cfg_data[W_SCALE-1:0];
        REG_CENTER_X:   center_x   <= cfg_data;
        REG_CENTER_Y:   center_y   <= cfg_data;
        REG_MAP_RADIUS: map_radius <= cfg_data[W_RAD-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NST-1:0] v;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[OST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: offsets
  logic [W_DIFF-1:0] dx;
  logic [W_DIFF-1:0] dz;
  logic              kind1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx    <= {in_data.object_x[W_WORLD-1], in_data.object_x}
             - {in_data.viewer_x[W_WORLD-1], in_data.viewer_x};
      dz    <= {in_data.object_z[W_WORLD-1], in_data.object_z}
             - {in_data.viewer_z[W_WORLD-1], in_data.viewer_z};
      kind1 <= in_data.object_kind;
    end
  end

  // stage 2: scale and round, z negated
  logic [W_MAG-1:0]          magx, magz;
  logic [W_MAG+W_SCALE-1:0]  prodx, prodz;
  mcc_side_t                 s2;

  always_comb begin
    magx  = dx[W_DIFF-1] ? W_MAG'(-dx) : dx;
    magz  = dz[W_DIFF-1] ? W_MAG'(-dz) : dz;
    prodx = (W_MAG+W_SCALE)'(magx) * (W_MAG+W_SCALE)'(map_scale)
          + (W_MAG+W_SCALE)'(2048);
    prodz = (W_MAG+W_SCALE)'(magz) * (W_MAG+W_SCALE)'(map_scale)
          + (W_MAG+W_SCALE)'(2048);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2.ax    <= prodx[W_MAG+W_SCALE-1:W_SCALE];
      s2.ay    <= prodz[W_MAG+W_SCALE-1:W_SCALE];
      s2.sx    <= dx[W_DIFF-1];
      s2.sy    <= !dz[W_DIFF-1] && (dz != '0);
      s2.kind  <= kind1;
      s2.clamp <= 1'b0;
    end
  end

  // stage 3: squares
  logic [W_SQ-1:0] sqx, sqy;
  logic [W_RR-1:0] rr;
  mcc_side_t       s3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sqx <= W_SQ'(s2.ax) * W_SQ'(s2.ax);
      sqy <= W_SQ'(s2.ay) * W_SQ'(s2.ay);
      rr  <= W_RR'(map_radius) * W_RR'(map_radius);
      s3  <= s2;
    end
  end

  // stage 4: distance squared and clamp decision
  logic [W_SQ-1:0] d2;
  mcc_side_t       s4;
  logic [W_SQ-1:0] d2_next;
  mcc_side_t       s4_next;

  assign d2_next = sqx + sqy;

  always_comb begin
    s4_next       = s3;
    s4_next.clamp = d2_next > W_SQ'(rr);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d2 <= d2_next;
      s4 <= s4_next;
    end
  end

  // square root chain
  logic [W_SQ-1:0] sq_rem  [0:SQRT_STEPS];
  logic [W_SQ-1:0] sq_root [0:SQRT_STEPS];
  mcc_side_t       sq_side [0:SQRT_STEPS];

  assign sq_rem[0]  = d2;
  assign sq_root[0] = '0;
  assign sq_side[0] = s4;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    mcc_sqrt_cell #(.SHIFT(W_SQ - 2 - 2 * k)) u_cell (
      .clk     (clk),
      .en      (adv[SQ0+k]),
      .rem_in  (sq_rem[k]),
      .root_in (sq_root[k]),
      .side_in (sq_side[k]),
      .rem     (sq_rem[k+1]),
      .root    (sq_root[k+1]),
      .side    (sq_side[k+1])
    );
  end

  // product by radius and rounding offset
  logic [W_MAG-1:0]       root_d;
  logic [W_MAG+W_RAD-1:0] nx, ny;
  logic [W_NUM-1:0]       mnum_x, mnum_y;
  logic [W_DEN-1:0]       mden;
  mcc_side_t              ms;

  assign root_d = sq_root[SQRT_STEPS][W_MAG-1:0];
  assign nx   = (W_MAG+W_RAD)'(sq_side[SQRT_STEPS].ax) * (W_MAG+W_RAD)'(map_radius);
  assign ny   = (W_MAG+W_RAD)'(sq_side[SQRT_STEPS].ay) * (W_MAG+W_RAD)'(map_radius);

  always_ff @(posedge clk) begin
    if (adv[MST]) begin
      mnum_x <= W_NUM'({nx, 1'b0}) + W_NUM'(root_d);
      mnum_y <= W_NUM'({ny, 1'b0}) + W_NUM'(root_d);
      mden   <= {root_d, 1'b0};
      ms     <= sq_side[SQRT_STEPS];
    end
  end

  // divider chain
  logic [W_NUM-1:0] dv_nx   [0:DIV_STEPS];
  logic [W_NUM-1:0] dv_ny   [0:DIV_STEPS];
  logic [W_DEN-1:0] dv_den  [0:DIV_STEPS];
  logic [W_Q-1:0]   dv_qx   [0:DIV_STEPS];
  logic [W_Q-1:0]   dv_qy   [0:DIV_STEPS];
  mcc_side_t        dv_side [0:DIV_STEPS];

  assign dv_nx[0]   = mnum_x;
  assign dv_ny[0]   = mnum_y;
  assign dv_den[0]  = mden;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = ms;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    mcc_div_cell #(.SHIFT(DIV_STEPS - 1 - j)) u_cell (
      .clk      (clk),
      .en       (adv[DV0+j]),
      .num_x_in (dv_nx[j]),
      .num_y_in (dv_ny[j]),
      .den_in   (dv_den[j]),
      .q_x_in   (dv_qx[j]),
      .q_y_in   (dv_qy[j]),
      .side_in  (dv_side[j]),
      .num_x    (dv_nx[j+1]),
      .num_y    (dv_ny[j+1]),
      .den      (dv_den[j+1]),
      .q_x      (dv_qx[j+1]),
      .q_y      (dv_qy[j+1]),
      .side     (dv_side[j+1])
    );
  end

  // output stage: pick clamped or direct magnitude, apply sign, add center
  mcc_side_t        fs;
  logic [W_CTR-1:0] fmag_x, fmag_y, fpx, fpy;

  assign fs = dv_side[DIV_STEPS];

  always_comb begin
    fmag_x = fs.clamp ? W_CTR'(dv_qx[DIV_STEPS]) : fs.ax[W_CTR-1:0];
    fmag_y = fs.clamp ? W_CTR'(dv_qy[DIV_STEPS]) : fs.ay[W_CTR-1:0];
    fpx    = fs.sx ? -fmag_x : fmag_x;
    fpy    = fs.sy ? -fmag_y : fmag_y;
  end

  always_ff @(posedge clk) begin
    if (adv[OST]) begin
      out_data.icon_x    <= center_x + fpx;
      out_data.icon_y    <= center_y + fpy;
      out_data.icon_kind <= fs.kind;
    end
  end

  // checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v[0])
    else $error("input stalled with first stage empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_unclamped_inside: assert property (@(posedge clk) disable iff (rst)
    v[3] && !s4.clamp |-> (s4.ax <= W_MAG'(map_radius)) && (s4.ay <= W_MAG'(map_radius)))
    else $error("unclamped point outside radius");

  a_root_covers: assert property (@(posedge clk) disable iff (rst)
    v[MST-1] && sq_side[SQRT_STEPS].clamp |-> root_d >= sq_side[SQRT_STEPS].ax)
    else $error("root below component magnitude");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    v[OST-1] && fs.clamp |-> (dv_qx[DIV_STEPS] <= map_radius)
                         && (dv_qy[DIV_STEPS] <= map_radius))
    else $error("clamped component beyond radius");

endmodule
`default_nettype wire

// ----- verif/tb_minimap_project_clamp_circle_top.sv -----
// Testbench for the minimap circle clamp: scoreboard class, stimulus tasks and checks.
`timescale 1ns / 1ps
module tb_minimap_project_clamp_circle_top;
  import mcc_pkg::*;

  // Expected icons and the projection predictor that fills them.
  class icon_scoreboard;
    mcc_out_t           pending_icons[$];
    logic [W_SCALE-1:0] scale;
    logic signed [15:0] cx, cy;
    logic [W_RAD-1:0]   radius;
    int                 mismatches;
    int                 checked;

    function void reset_regs();
      scale = SCALE_RESET;
      cx = 0;
      cy = 0;
      radius = RADIUS_RESET;
    endfunction

    function void write_reg(logic [W_CIDX-1:0] idx, logic [W_CDAT-1:0] data);
      case (idx)
        REG_MAP_SCALE:  scale = data[W_SCALE-1:0];
        REG_CENTER_X:   cx = data;
        REG_CENTER_Y:   cy = data;
        REG_MAP_RADIUS: radius = data[W_RAD-1:0];
        default: ;
      endcase
    endfunction

    // Divide rounding half away from zero, then apply the sign.
    function longint round_div(longint unsigned num, longint unsigned den, bit neg);
      longint unsigned q;
      q = (2 * num + den) / (2 * den);
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      r = 0;
      for (int b = 31; b >= 0; b--)
        if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r = r | (64'd1 << b);
      return r;
    endfunction

    function void note_object(mcc_in_t it);
      longint dx, dz, rx, ry, px, py;
      longint unsigned ax, ay, d2, root_d;
      mcc_out_t e;
      dx = longint'(it.object_x) - longint'(it.viewer_x);
      dz = longint'(it.object_z) - longint'(it.viewer_z);
      rx = round_div((dx < 0 ? -dx : dx) * scale, 4096, dx < 0);
      ry = round_div((dz < 0 ? -dz : dz) * scale, 4096, dz > 0);
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      d2 = ax * ax + ay * ay;
      if (d2 <= longint'(radius) * radius) begin
        px = rx;
        py = ry;
      end else begin
        root_d = int_sqrt(d2);
        px = round_div(ax * radius, root_d, rx < 0);
        py = round_div(ay * radius, root_d, ry < 0);
      end
      e.icon_x = 16'(cx + px);
      e.icon_y = 16'(cy + py);
      e.icon_kind = it.object_kind;
      pending_icons.insert(pending_icons.size(), e);
    endfunction

    function void check_icon(mcc_out_t got);
      mcc_out_t e;
      if (pending_icons.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected icon %p", got);
        return;
      end
      e = pending_icons.pop_front();
      checked++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("icon error: exp %p got %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic in_stall, out_valid, cfg_ready;
  mcc_in_t in_data = '0;
  mcc_out_t out_data;
  logic [W_CIDX-1:0] cfg_index = '0;
  logic [W_CDAT-1:0] cfg_data = '0;
  icon_scoreboard sb;
  int stall_mode = 0;
  int objects_sent = 0;
  int clamp_cases = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  minimap_project_clamp_circle_top uut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_icon(out_data);
    // receiver pattern: none, sparse, heavy, random quarter
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 9) == 0);
      2: out_stall <= ($urandom_range(0, 2) != 0);
      default: out_stall <= (($urandom_range(0, 7) & 3) == 0);
    endcase
  end

  task automatic write_reg(mcc_reg_t idx, logic [W_CDAT-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.write_reg(idx, data);
  endtask

  // Hold the item until the transfer happens.
  task automatic send_object(mcc_in_t it);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_object(it);
    objects_sent++;
  endtask

  task automatic idle_sender(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_icons.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic mcc_in_t rand_object(int spread);
    mcc_in_t it;
    it.viewer_x = $urandom;
    it.viewer_z = $urandom;
    it.object_kind = $urandom;
    case (spread)
      0: begin
        it.object_x = it.viewer_x + $signed($urandom_range(0, 8191)) - 4096;
        it.object_z = it.viewer_z + $signed($urandom_range(0, 8191)) - 4096;
      end
      1: begin
        it.object_x = it.viewer_x + $signed($urandom_range(0, 131071)) - 65536;
        it.object_z = it.viewer_z + $signed($urandom_range(0, 131071)) - 65536;
      end
      default: begin
        it.object_x = $urandom;
        it.object_z = $urandom;
      end
    endcase
    return it;
  endfunction

  task automatic random_phase(int count);
    int burst;
    for (int i = 0; i < count;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && i < count; k++, i++)
        send_object(rand_object($urandom_range(0, 2)));
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  localparam logic signed [23:0] WMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] WMIN = -24'sh800000;

  initial begin
    mcc_in_t it;
    sb = new();
    sb.reset_regs();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero offset, extremes, axis points, tag values
    it = '{WMAX, WMAX, WMAX, WMAX, 1'b1}; send_object(it);
    it = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}; send_object(it);
    it = '{WMAX, WMIN, WMIN, WMAX, 1'b0}; send_object(it);
    it = '{WMIN, WMAX, WMAX, WMIN, 1'b1}; send_object(it);
    it = '{24'sd5120, 24'sd0, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    it = '{24'sd0, -24'sd5121, 24'sd0, 24'sd0, 1'b0}; send_object(it);
    it = '{24'sd8, 24'sd8, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    it = '{-24'sd8, -24'sd24, 24'sd0, 24'sd0, 1'b0}; send_object(it);
    it = '{24'sd3000, 24'sd4000, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    drain();

    // zero radius, zero scale, then extremes
    write_reg(REG_MAP_RADIUS, 16'd0);
    it = '{24'sd300, 24'sd77, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    it = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}; send_object(it);
    drain();
    write_reg(REG_MAP_SCALE, 16'd0);
    write_reg(REG_MAP_RADIUS, 16'd8191);
    it = '{WMAX, WMIN, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    drain();
    write_reg(REG_MAP_SCALE, 16'hFFFF);
    write_reg(REG_CENTER_X, 16'hFFFF);
    write_reg(REG_CENTER_Y, 16'hE700);
    it = '{WMAX, WMIN, WMIN, WMAX, 1'b0}; send_object(it);
    it = '{24'sd100, 24'sd100, 24'sd0, 24'sd0, 1'b1}; send_object(it);
    drain();

    // random phases across register settings and stall patterns
    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 4;
      write_reg(REG_MAP_SCALE, (ph == 1) ? 16'd4095 : 16'($urandom_range(0, 4095)));
      write_reg(REG_CENTER_X, (ph == 2) ? 16'sd20480 : 16'($urandom_range(0, 26880) - 6400));
      write_reg(REG_CENTER_Y, (ph == 2) ? -16'sd6400 : 16'($urandom_range(0, 26880) - 6400));
      write_reg(REG_MAP_RADIUS, (ph == 3) ? 16'd8191 : 16'($urandom_range(0, 8191)));
      if (ph == 5) write_reg(mcc_reg_t'(8'd9), 16'hFFFF);
      random_phase(125);
      drain();
    end
    stall_mode = 0;

    $display("sent %0d objects, checked %0d icons over 8 random register settings",
             objects_sent, sb.checked);
    $display("covered zero radius, zero scale, extreme centers and stall patterns");
    if (sb.mismatches == 0 && sb.pending_icons.size() == 0)
      $display("minimap_project_clamp_circle_top: match");
    else
      $display("minimap_project_clamp_circle_top: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("minimap_project_clamp_circle_top: mismatch");
    $finish;
  end
endmodule
